// ===== sv/jts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the JSON token scanner
// Item formats of both channels, token kinds, error codes and character
// classes used by the scanner and its channel interfaces.
// ----------------------------------------------------------------------------
package jts_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic [23:0] start_offset;
    logic [6:0]  lexeme_length;
    logic        last_result;
  } out_item_t;

  // Token kinds.
  localparam logic [3:0] KIND_COLON    = 4'd0;
  localparam logic [3:0] KIND_COMMA    = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_LBRACE   = 4'd4;
  localparam logic [3:0] KIND_RBRACE   = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_FALSE    = 4'd9;
  localparam logic [3:0] KIND_NULL     = 4'd10;
  localparam logic [3:0] KIND_EOF      = 4'd11;
  localparam logic [3:0] KIND_ERROR    = 4'd12;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_BAD_WORD   = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
  localparam logic [2:0] ERR_NL_IN_STR  = 3'd4;
  localparam logic [2:0] ERR_TAB_IN_STR = 3'd5;
  localparam logic [2:0] ERR_EARLY_EOF  = 3'd6;
  localparam logic [2:0] ERR_BAD_NUMBER = 3'd7;

  // Characters.
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_E_LOWER  = 8'h65;
  localparam logic [7:0] CH_E_UPPER  = 8'h45;

  // Keywords as they sit right-aligned in the 40-bit word buffer.
  localparam logic [39:0] KW_TRUE_LO  = {8'h00, "true"};
  localparam logic [39:0] KW_TRUE_UP  = {8'h00, "TRUE"};
  localparam logic [39:0] KW_NULL_LO  = {8'h00, "null"};
  localparam logic [39:0] KW_NULL_UP  = {8'h00, "NULL"};
  localparam logic [39:0] KW_FALSE_LO = "false";
  localparam logic [39:0] KW_FALSE_UP = "FALSE";

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage
`default_nettype wire

// ===== sv/jts_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jts_in_if: input byte channel of the JSON token scanner
// Valid/ready channel carrying one byte or an end-of-input mark per transfer.
// ----------------------------------------------------------------------------
interface jts_in_if;
  import jts_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/jts_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jts_out_if: token channel of the JSON token scanner
// Valid/ready channel carrying one token record per transfer.
// ----------------------------------------------------------------------------
interface jts_out_if;
  import jts_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/json_token_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_scanner: streaming JSON lexer, one byte per transfer
// Turns a byte stream into JSON tokens with line, offset and length.
// ----------------------------------------------------------------------------
// The scanner takes one byte (or an end-of-input mark) per transfer and can
// take a new one in every clock cycle while the result queue has room. A
// byte is held in an input register, where a shallow state update classifies
// it; the token records it causes (none, one or two) are written into a
// four-entry result queue that drives the output channel, so a record passes
// through the input register and the result queue before it is offered. The
// output side moves one record per cycle while the receiver is ready, so a
// byte that yields two records (a delimiter that closes a word or number, or
// an end mark behind a pending token) leaves as two transfers; the input
// stalls only when the result queue cannot take two more records.
// Errors report a code and then all bytes up to the next newline are
// dropped; lexemes longer than MAX_LEXEME bytes give a too-long error.
// ----------------------------------------------------------------------------
module json_token_scanner #(
  parameter int MAX_LEXEME = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  jts_in_if.sink     in_ch,
  jts_out_if.source  out_ch
);
  import jts_pkg::*;

  // Lexeme counter wide enough to hold MAX_LEXEME itself.
  localparam int CW = $clog2(MAX_LEXEME + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEXEME);

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STR,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_EXP0,
    MODE_ESIGN,
    MODE_EXP
  } mode_t;

  // --------------------------------------------------------------------------
  // Input register. The scanner state advances when the held byte is
  // processed, which happens whenever the result queue has room for the two
  // records a byte can cause at most.
  // --------------------------------------------------------------------------
  logic            s1_valid_r;
  in_item_t        s1_item_r;
  logic [QCW-1:0]  q_cnt_r;
  logic            fire;

  assign fire        = s1_valid_r && (q_cnt_r <= QCW'(QDEPTH - 2));
  assign in_ch.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.data;
    end
  end

  // --------------------------------------------------------------------------
  // Scanner state.
  // --------------------------------------------------------------------------
  mode_t          mode_r,  mode_nxt;
  logic [39:0]    buf_r,   buf_nxt;
  logic [CW-1:0]  cnt_r,   cnt_nxt;
  logic [23:0]    start_r, start_nxt;
  logic [23:0]    pos_r,   pos_nxt;
  logic [15:0]    line_r,  line_nxt;
  logic           skip_r,  skip_nxt;

  // Record A is the token that was pending (word, number, string, error),
  // record B is the one caused by the byte itself when it is seen between
  // tokens, or the end-of-file record. A always comes out before B.
  logic           a_vld, b_vld;
  logic [3:0]     a_kind, b_kind;
  logic [2:0]     a_code, b_code;
  logic [23:0]    a_start, b_start;
  logic [CW-1:0]  a_len, b_len;

  logic [7:0]     b;
  logic           eoi;
  logic           do_idle, do_fail, do_grow;
  logic [2:0]     fail_code;
  logic [15:0]    line_inc;
  logic [3:0]     kw_kind;
  logic           kw_hit;
  logic           b_dig, b_exp;
  mode_t          num_next;
  logic           num_bad;

  assign b     = s1_item_r.byte_value;
  assign eoi   = s1_item_r.end_of_input;
  assign b_dig = is_digit(b);
  assign b_exp = (b == CH_E_LOWER) || (b == CH_E_UPPER);

  // Line counter saturates at its top value.
  assign line_inc = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;

  // Keyword match on the buffered word.
  always_comb begin
    kw_kind = KIND_ERROR;
    kw_hit  = 1'b0;
    if ((cnt_r == CW'(4)) && ((buf_r == KW_TRUE_LO) || (buf_r == KW_TRUE_UP))) begin
      kw_kind = KIND_TRUE;
      kw_hit  = 1'b1;
    end else if ((cnt_r == CW'(5)) &&
                 ((buf_r == KW_FALSE_LO) || (buf_r == KW_FALSE_UP))) begin
      kw_kind = KIND_FALSE;
      kw_hit  = 1'b1;
    end else if ((cnt_r == CW'(4)) &&
                 ((buf_r == KW_NULL_LO) || (buf_r == KW_NULL_UP))) begin
      kw_kind = KIND_NULL;
      kw_hit  = 1'b1;
    end
  end

  // Number grammar: the mode a byte leads to, or a malformed number.
  always_comb begin
    num_next = MODE_IDLE;
    num_bad  = 1'b0;
    case (mode_r)
      MODE_INT: begin
        if (b_dig)              num_next = MODE_INT;
        else if (b == CH_DOT)   num_next = MODE_DOT;
        else if (b_exp)         num_next = MODE_EXP0;
      end
      MODE_DOT: begin
        if (b_dig) num_next = MODE_FRAC;
        else       num_bad  = 1'b1;
      end
      MODE_FRAC: begin
        if (b_dig)      num_next = MODE_FRAC;
        else if (b_exp) num_next = MODE_EXP0;
      end
      MODE_EXP0: begin
        if ((b == CH_PLUS) || (b == CH_MINUS)) num_next = MODE_ESIGN;
        else if (b_dig)                        num_next = MODE_EXP;
        else                                   num_bad  = 1'b1;
      end
      MODE_ESIGN: begin
        if (b_dig) num_next = MODE_EXP;
        else       num_bad  = 1'b1;
      end
      default: begin
        if (b_dig) num_next = MODE_EXP;
      end
    endcase
  end

  // Per-byte state update.
  always_comb begin
    mode_nxt  = mode_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    skip_nxt  = skip_r;

    a_vld   = 1'b0;
    a_kind  = KIND_ERROR;
    a_code  = ERR_NONE;
    a_start = start_r;
    a_len   = cnt_r;
    b_vld   = 1'b0;
    b_kind  = KIND_EOF;
    b_code  = ERR_NONE;
    b_start = pos_r;
    b_len   = '0;

    do_idle   = 1'b0;
    do_fail   = 1'b0;
    do_grow   = 1'b0;
    fail_code = ERR_NONE;

    if (eoi) begin
      // Flush whatever is pending, then report end of file.
      unique case (mode_r)
        MODE_IDLE: ;
        MODE_WORD: begin
          a_vld  = 1'b1;
          a_kind = kw_kind;
          a_code = kw_hit ? ERR_NONE : ERR_BAD_WORD;
        end
        MODE_INT, MODE_FRAC, MODE_EXP: begin
          a_vld  = 1'b1;
          a_kind = KIND_NUMBER;
        end
        default: begin
          a_vld  = 1'b1;
          a_kind = KIND_ERROR;
          a_code = ERR_EARLY_EOF;
        end
      endcase
      mode_nxt = MODE_IDLE;
      skip_nxt = 1'b0;
      b_vld    = 1'b1;
    end else if (skip_r) begin
      if (b == CH_NEWLINE) begin
        line_nxt = line_inc;
        skip_nxt = 1'b0;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: do_idle = 1'b1;
        MODE_WORD: begin
          if (is_letter(b)) begin
            if (cnt_r >= MAX_CNT) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOO_LONG;
            end else begin
              do_grow = 1'b1;
            end
          end else if (kw_hit) begin
            a_vld   = 1'b1;
            a_kind  = kw_kind;
            do_idle = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_WORD;
          end
        end
        MODE_STR: begin
          if (cnt_r >= MAX_CNT) begin
            do_fail   = 1'b1;
            fail_code = ERR_TOO_LONG;
          end else if (b == CH_NEWLINE) begin
            do_fail   = 1'b1;
            fail_code = ERR_NL_IN_STR;
          end else if (b == CH_TAB) begin
            do_fail   = 1'b1;
            fail_code = ERR_TAB_IN_STR;
          end else begin
            do_grow = 1'b1;
            if (b == CH_QUOTE) begin
              // The closing quote counts toward the string's length.
              a_vld    = 1'b1;
              a_kind   = KIND_STRING;
              a_len    = cnt_r + CW'(1);
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: begin
          if (num_bad) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_NUMBER;
          end else if (num_next == MODE_IDLE) begin
            a_vld   = 1'b1;
            a_kind  = KIND_NUMBER;
            do_idle = 1'b1;
          end else if (cnt_r >= MAX_CNT) begin
            do_fail   = 1'b1;
            fail_code = ERR_TOO_LONG;
          end else begin
            do_grow  = 1'b1;
            mode_nxt = num_next;
          end
        end
      endcase
    end

    if (do_grow) begin
      cnt_nxt = cnt_r + CW'(1);
      buf_nxt = {buf_r[31:0], b};
    end

    // An error reports the lexeme so far and starts dropping the line; a
    // newline that caused the error ends the drop right away.
    if (do_fail) begin
      a_vld    = 1'b1;
      a_kind   = KIND_ERROR;
      a_code   = fail_code;
      mode_nxt = MODE_IDLE;
      if (b == CH_NEWLINE) begin
        line_nxt = line_inc;
        skip_nxt = 1'b0;
      end else begin
        skip_nxt = 1'b1;
      end
    end

    // Handling of a byte seen between tokens.
    if (do_idle) begin
      mode_nxt = MODE_IDLE;
      b_kind   = KIND_ERROR;
      b_len    = CW'(1);
      case (b)
        CH_SPACE, CH_TAB: ;
        CH_NEWLINE:  line_nxt = line_inc;
        CH_COLON: begin
          b_vld  = 1'b1;
          b_kind = KIND_COLON;
        end
        CH_COMMA: begin
          b_vld  = 1'b1;
          b_kind = KIND_COMMA;
        end
        CH_LBRACKET: begin
          b_vld  = 1'b1;
          b_kind = KIND_LBRACKET;
        end
        CH_RBRACKET: begin
          b_vld  = 1'b1;
          b_kind = KIND_RBRACKET;
        end
        CH_LBRACE: begin
          b_vld  = 1'b1;
          b_kind = KIND_LBRACE;
        end
        CH_RBRACE: begin
          b_vld  = 1'b1;
          b_kind = KIND_RBRACE;
        end
        CH_QUOTE: begin
          mode_nxt  = MODE_STR;
          start_nxt = pos_r;
          cnt_nxt   = CW'(1);
          buf_nxt   = {32'h0, b};
        end
        default: begin
          if (is_letter(b) || b_dig) begin
            mode_nxt  = is_letter(b) ? MODE_WORD : MODE_INT;
            start_nxt = pos_r;
            cnt_nxt   = CW'(1);
            buf_nxt   = {32'h0, b};
          end else begin
            // A byte that starts no token: one-byte error, then drop the line.
            b_vld     = 1'b1;
            b_code    = ERR_UNEXPECTED;
            start_nxt = pos_r;
            cnt_nxt   = CW'(1);
            skip_nxt  = 1'b1;
          end
        end
      endcase
    end

    // The byte position counts bytes only and saturates.
    if (!eoi && (pos_r != 24'hFFFFFF)) begin
      pos_nxt = pos_r + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      buf_r   <= '0;
      cnt_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      line_r  <= 16'd1;
      skip_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue. Up to two records are written per processed byte, in
  // order; the head entry drives the output channel.
  // --------------------------------------------------------------------------
  out_item_t      rec0, rec1;
  logic [1:0]     push_n;
  logic           pop;
  out_item_t      q_r [QDEPTH];
  logic [QPW-1:0] q_wr_r, q_rd_r;

  always_comb begin
    rec1.token_kind    = b_kind;
    rec1.error_code    = b_code;
    rec1.line_number   = line_r;
    rec1.start_offset  = b_start;
    rec1.lexeme_length = 7'(b_len);
    rec1.last_result   = 1'b1;

    if (a_vld) begin
      rec0.token_kind    = a_kind;
      rec0.error_code    = a_code;
      rec0.line_number   = line_r;
      rec0.start_offset  = a_start;
      rec0.lexeme_length = 7'(a_len);
      rec0.last_result   = !b_vld;
    end else begin
      rec0 = rec1;
    end

    push_n = fire ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
  end

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (q_cnt_r != '0);
  assign out_ch.data  = q_r[q_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_r + QCW'(push_n) - QCW'(pop);
      q_wr_r  <= q_wr_r + QPW'(push_n);
      if (pop) begin
        q_rd_r <= q_rd_r + QPW'(1);
      end
    end
    if (push_n != 2'd0) begin
      q_r[q_wr_r] <= rec0;
    end
    if (push_n == 2'd2) begin
      q_r[q_wr_r + QPW'(1)] <= rec1;
    end
  end

endmodule
`default_nettype wire
